/* src/lexicographic_permutation_step_macros.svh */
// assertion macros shared by the lexicographic permutation step checkers
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef LEXICOGRAPHIC_PERMUTATION_STEP_MACROS_SVH
`define LEXICOGRAPHIC_PERMUTATION_STEP_MACROS_SVH

// property checked outside reset
`define LPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every edge, reset included
`define LPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/lps_pkg.sv */
// shared constants for the lexicographic permutation step
// no dependencies
package lps_pkg;

  // default geometry of the packed sequence
  localparam int MAX_ELEMENTS_DEF = 8;
  localparam int ELEMENT_BITS_DEF = 4;

  // configuration port
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;
  localparam int CFG_W   = 4;

  // register map
  localparam logic [PADDR_W-1:0] ADDR_LENGTH_IN_USE  = 3'h0;
  localparam logic [CFG_W-1:0]   LENGTH_IN_USE_RESET = 4'd8;

endpackage

/* src/lps_lane.sv */
// one compare lane: ordered compare of two elements with direction select
// depends on nothing but its ports
module lps_lane #(
  parameter int ELEMENT_BITS = lps_pkg::ELEMENT_BITS_DEF
) (
  input  logic [ELEMENT_BITS-1:0] x_i,
  input  logic [ELEMENT_BITS-1:0] y_i,
  input  logic                    back_i,
  input  logic                    en_i,
  output logic                    hit_o
);

  // forward wants x < y, backward wants x > y
  always_comb begin
    hit_o = en_i & (back_i ? (x_i > y_i) : (x_i < y_i));
  end

endmodule

/* src/lps_merge.sv */
// merging stage: picks the highest lane index whose flag is set
// depends on nothing but its ports
module lps_merge #(
  parameter int MAX_ELEMENTS = lps_pkg::MAX_ELEMENTS_DEF,
  localparam int IDX_W = $clog2(MAX_ELEMENTS)
) (
  input  logic [MAX_ELEMENTS-1:0] flags_i,
  output logic                    found_o,
  output logic [IDX_W-1:0]        idx_o
);

  // rightmost set flag wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (flags_i[k]) begin
        found_o = 1'b1;
        idx_o   = IDX_W'(k);
      end
    end
  end

endmodule

/* src/lps_permute.sv */
// output stage: swaps pivot and successor, reverses the suffix
// depends on nothing but its ports
module lps_permute #(
  parameter int MAX_ELEMENTS = lps_pkg::MAX_ELEMENTS_DEF,
  parameter int ELEMENT_BITS = lps_pkg::ELEMENT_BITS_DEF,
  localparam int WORD_W = MAX_ELEMENTS * ELEMENT_BITS,
  localparam int IDX_W  = $clog2(MAX_ELEMENTS),
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic [WORD_W-1:0] word_i,
  input  logic [CNT_W-1:0]  n_i,
  input  logic [IDX_W-1:0]  piv_i,
  input  logic [IDX_W-1:0]  succ_i,
  input  logic              found_i,
  output logic [WORD_W-1:0] word_o
);

  localparam int SUM_W = CNT_W + 1;

  logic [ELEMENT_BITS-1:0] elem [MAX_ELEMENTS];
  logic [ELEMENT_BITS-1:0] piv_val;
  logic [ELEMENT_BITS-1:0] succ_val;

  // unpack and pick the two swapped values
  always_comb begin
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      elem[k] = word_i[k*ELEMENT_BITS +: ELEMENT_BITS];
    end
    piv_val  = elem[piv_i];
    succ_val = elem[succ_i];
  end

  // each position gathers its element from the mirrored suffix slot
  always_comb begin
    logic [IDX_W-1:0] src;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      src = IDX_W'(SUM_W'(piv_i) + SUM_W'(n_i) - SUM_W'(k));
      word_o[k*ELEMENT_BITS +: ELEMENT_BITS] = elem[k];
      if (found_i) begin
        if (IDX_W'(k) == piv_i) begin
          word_o[k*ELEMENT_BITS +: ELEMENT_BITS] = succ_val;
        end else if (IDX_W'(k) > piv_i && CNT_W'(k) < n_i) begin
          word_o[k*ELEMENT_BITS +: ELEMENT_BITS] = (src == succ_i) ? piv_val : elem[src];
        end
      end
    end
  end

endmodule

/* src/lexicographic_permutation_step.sv */
// top level of the lexicographic permutation step: lanes, merges, output stage
// depends on lps_pkg, lps_lane, lps_merge, lps_permute
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  request   | start / busy          | sequence_in_i, go_backward_i
//  result    | done_o (one cycle)    | sequence_out_o, no_neighbor_o
//  config    | psel/penable/pwrite   | paddr, pwdata, prdata (length_in_use)
//
// a request passes from accept to done_o through the stage 1, stage 2 and result registers, and one enters every cycle
// three register stages hold the results of pivot search, successor search and permute
// busy stays low; the result is shown for one cycle and cannot be held off
// rst_ni clears all valid bits and sets length_in_use to 8
module lexicographic_permutation_step #(
  parameter int MAX_ELEMENTS = lps_pkg::MAX_ELEMENTS_DEF,
  parameter int ELEMENT_BITS = lps_pkg::ELEMENT_BITS_DEF,
  localparam int WORD_W = MAX_ELEMENTS * ELEMENT_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [WORD_W-1:0]           sequence_in_i,
  input  logic                        go_backward_i,
  output logic                        done_o,
  output logic [WORD_W-1:0]           sequence_out_o,
  output logic                        no_neighbor_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::PADDR_W-1:0] paddr,
  input  logic [lps_pkg::DATA_W-1:0]  pwdata,
  output logic [lps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  import lps_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [CFG_W-1:0] length_q;
  logic             cfg_wr;
  logic [CNT_W-1:0] n_cur;
  logic             accept;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_LENGTH_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LENGTH_IN_USE_RESET;
    end else if (cfg_wr) begin
      length_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_LENGTH_IN_USE) ? DATA_W'(length_q) : '0;

  // effective length: zero acts as one, clipped to the element count
  always_comb begin
    if (length_q == '0) begin
      n_cur = CNT_W'(1);
    end else if ({1'b0, length_q} > (CFG_W+1)'(MAX_ELEMENTS)) begin
      n_cur = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_cur = CNT_W'(length_q);
    end
  end

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // stage 0 lanes: ascent or descent between neighbors
  logic [MAX_ELEMENTS-1:0] asc_flags;
  logic                    piv_found;
  logic [IDX_W-1:0]        piv_idx;

  for (genvar p = 0; p < MAX_ELEMENTS - 1; p++) begin : g_asc
    lps_lane #(.ELEMENT_BITS(ELEMENT_BITS)) u_lane (
      .x_i    (sequence_in_i[p*ELEMENT_BITS +: ELEMENT_BITS]),
      .y_i    (sequence_in_i[(p+1)*ELEMENT_BITS +: ELEMENT_BITS]),
      .back_i (go_backward_i),
      .en_i   (CNT_W'(p + 1) < n_cur),
      .hit_o  (asc_flags[p])
    );
  end
  assign asc_flags[MAX_ELEMENTS-1] = 1'b0;

  lps_merge #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_merge_piv (
    .flags_i (asc_flags),
    .found_o (piv_found),
    .idx_o   (piv_idx)
  );

  // stage 1 registers
  logic              v1_q;
  logic [WORD_W-1:0] word1_q;
  logic              back1_q;
  logic [CNT_W-1:0]  n1_q;
  logic [IDX_W-1:0]  piv1_q;
  logic              found1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word1_q  <= sequence_in_i;
      back1_q  <= go_backward_i;
      n1_q     <= n_cur;
      piv1_q   <= piv_idx;
      found1_q <= piv_found;
    end
  end

  // stage 1 lanes: suffix elements beyond the pivot value
  logic [ELEMENT_BITS-1:0] piv1_val;
  logic [MAX_ELEMENTS-1:0] succ_flags;
  logic                    succ_found;
  logic [IDX_W-1:0]        succ_idx;

  always_comb begin
    piv1_val = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (IDX_W'(k) == piv1_q) begin
        piv1_val = word1_q[k*ELEMENT_BITS +: ELEMENT_BITS];
      end
    end
  end

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_succ
    lps_lane #(.ELEMENT_BITS(ELEMENT_BITS)) u_lane (
      .x_i    (piv1_val),
      .y_i    (word1_q[k*ELEMENT_BITS +: ELEMENT_BITS]),
      .back_i (back1_q),
      .en_i   ((IDX_W'(k) > piv1_q) && (CNT_W'(k) < n1_q)),
      .hit_o  (succ_flags[k])
    );
  end

  lps_merge #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_merge_succ (
    .flags_i (succ_flags),
    .found_o (succ_found),
    .idx_o   (succ_idx)
  );

  // stage 2 registers
  logic              v2_q;
  logic [WORD_W-1:0] word2_q;
  logic [CNT_W-1:0]  n2_q;
  logic [IDX_W-1:0]  piv2_q;
  logic [IDX_W-1:0]  succ2_q;
  logic              found2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  // a found pivot always has its right neighbor as a candidate successor
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      word2_q  <= word1_q;
      n2_q     <= n1_q;
      piv2_q   <= piv1_q;
      succ2_q  <= succ_idx;
      found2_q <= found1_q & succ_found;
    end
  end

  // swap and suffix reversal
  logic [WORD_W-1:0] perm_word;

  lps_permute #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_permute (
    .word_i  (word2_q),
    .n_i     (n2_q),
    .piv_i   (piv2_q),
    .succ_i  (succ2_q),
    .found_i (found2_q),
    .word_o  (perm_word)
  );

  // result register
  logic              done_q;
  logic [WORD_W-1:0] seq_q;
  logic              nn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      seq_q <= perm_word;
      nn_q  <= ~found2_q;
    end
  end

  assign done_o         = done_q;
  assign sequence_out_o = seq_q;
  assign no_neighbor_o  = nn_q;

endmodule

/* src/lps_checker.sv */
// port-level checker for the lexicographic permutation step, bound to the top level
// depends on lps_pkg and lexicographic_permutation_step_macros.svh
`include "lexicographic_permutation_step_macros.svh"

module lps_checker #(
  parameter int MAX_ELEMENTS = lps_pkg::MAX_ELEMENTS_DEF,
  parameter int ELEMENT_BITS = lps_pkg::ELEMENT_BITS_DEF,
  localparam int WORD_W = MAX_ELEMENTS * ELEMENT_BITS
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [WORD_W-1:0] sequence_in_i,
  input logic              done_o,
  input logic [WORD_W-1:0] sequence_out_o,
  input logic              no_neighbor_o
);

  import lps_pkg::*;

  logic req_acc;
  assign req_acc = start & ~busy;

  // every accepted request gives a result on done_o
  `LPS_ASSERT(a_req_done, req_acc |-> ##3 done_o, "accepted request gave no result")

  // no result without an earlier accepted request
  `LPS_ASSERT(a_done_req, done_o |-> $past(req_acc, 3), "result without request")

  // no neighbor returns the input unchanged
  `LPS_ASSERT(a_unchanged, (done_o && no_neighbor_o) |-> (sequence_out_o == $past(sequence_in_i, 3)), "flagged result differs from input")

  // a real step always moves something
  `LPS_ASSERT(a_moved, (done_o && !no_neighbor_o) |-> (sequence_out_o != $past(sequence_in_i, 3)), "step returned the input")

  // reset silences the result strobe from the following edge on
  `LPS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !done_o, "result strobe during reset")

endmodule

bind lexicographic_permutation_step lps_checker #(
  .MAX_ELEMENTS (MAX_ELEMENTS),
  .ELEMENT_BITS (ELEMENT_BITS)
) u_lps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .sequence_in_i  (sequence_in_i),
  .done_o         (done_o),
  .sequence_out_o (sequence_out_o),
  .no_neighbor_o  (no_neighbor_o)
);
